/* sv/tmps_pkg.sv */
// shared constants, types and helpers for the triangle minimum path sum block
package tmps_pkg;

    // largest triangle the row buffer holds
    localparam int MAX_ROWS = 64;

    // field widths
    localparam int CFG_W   = 7;
    localparam int VALUE_W = 16;
    localparam int OUT_W   = 22;

    // derived widths
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int COL_W = $clog2(MAX_ROWS);
    localparam int SUM_W = VALUE_W + COL_W + 1;
    localparam int CMP_W = (ROW_W > CFG_W) ? ROW_W : CFG_W;

    // row count register value after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef logic [ROW_W-1:0]          t_rows;
    typedef logic [COL_W-1:0]          t_col;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [OUT_W-1:0]   t_out;

    // element issued to the fold datapath
    typedef struct packed {
        logic   valid;
        logic   bottom;
        logic   apex;
        t_col   col;
        t_value value;
    } t_issue;

    // element leaving the fold stage
    typedef struct packed {
        logic valid;
        logic apex;
        t_sum sum;
    } t_fold_res;

    // row count in use: zero means one row, large values saturate
    function automatic t_rows eff_rows(input logic [CFG_W-1:0] cfg);
        logic [CMP_W-1:0] c;
        t_rows            r;
        c = CMP_W'(cfg);
        if (c == '0) begin
            r = ROW_W'(1);
        end else if (c > CMP_W'(MAX_ROWS)) begin
            r = ROW_W'(MAX_ROWS);
        end else begin
            r = ROW_W'(c);
        end
        return r;
    endfunction

endpackage

/* sv/tmps_in_if.sv */
// element stream channel
interface tmps_in_if import tmps_pkg::*; ();
    logic   valid;
    logic   ready;
    t_value value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

/* sv/tmps_out_if.sv */
// minimum sum result channel
interface tmps_out_if import tmps_pkg::*; ();
    logic valid;
    logic ready;
    t_out min_sum;

    modport source (output valid, output min_sum, input ready);
    modport sink   (input valid, input min_sum, output ready);
endinterface

/* sv/triangle_min_path_sum_core.sv */
// Minimum top-to-bottom path sum of a number triangle. Elements arrive one
// beat per cycle, bottom row first and each row left to right; the row count
// comes from i_cfg_data (zero means one row, values above the buffer size
// saturate) and a write restarts the triangle. Each element passes the input
// and then the fold stage, which reads two entries of the row buffer memory,
// copies a bottom-row element or adds the smaller entry to the element, and
// writes back, with the write just issued forwarded to the next read. The
// result beat leaves from an output register loaded with the apex result;
// input stalls only while the fold stage holds an apex whose result cannot
// enter a still occupied output register.
module triangle_min_path_sum_core import tmps_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    tmps_in_if.sink          i_in,
    tmps_out_if.source       o_out
);

    logic [CFG_W-1:0] r_cfg;
    t_rows            r_row_left;
    t_rows            n_row_left;
    t_col             r_col;
    t_col             n_col;
    logic             r_out_valid;
    t_out             r_out_sum;

    t_rows            rows;
    t_rows            col_next;
    logic             accept;
    logic             out_ok;
    logic             advance;
    t_issue           issue;
    t_fold_res        res;

    assign rows    = eff_rows(r_cfg);
    assign out_ok  = !r_out_valid || o_out.ready;
    assign advance = res.valid && (!res.apex || out_ok);

    // input beat handshake
    assign i_in.ready = !res.valid || advance;
    assign accept     = i_in.valid && i_in.ready;

    // element issue
    always_comb begin
        issue.valid  = accept;
        issue.bottom = (r_row_left == rows);
        issue.apex   = (r_row_left == ROW_W'(1));
        issue.col    = r_col;
        issue.value  = i_in.value;
    end

    // row and column tracking
    assign col_next = ROW_W'(r_col) + ROW_W'(1);

    always_comb begin
        n_row_left = r_row_left;
        n_col      = r_col;
        if (accept) begin
            if (col_next == r_row_left) begin
                n_col = '0;
                if (r_row_left == ROW_W'(1)) begin
                    n_row_left = rows;
                end else begin
                    n_row_left = r_row_left - ROW_W'(1);
                end
            end else begin
                n_col = COL_W'(col_next);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= CFG_RESET;
            r_row_left <= eff_rows(CFG_RESET);
            r_col      <= '0;
        end else if (i_cfg_we) begin
            r_cfg      <= i_cfg_data;
            r_row_left <= eff_rows(i_cfg_data);
            r_col      <= '0;
        end else begin
            r_row_left <= n_row_left;
            r_col      <= n_col;
        end
    end

    tmps_fold u_fold (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_issue   (issue),
        .i_advance (advance),
        .o_res     (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res.apex) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.apex) begin
            r_out_sum <= res.sum[OUT_W-1:0];
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.min_sum = r_out_sum;

endmodule

/* sv/tmps_fold.sv */
// row buffer memory with read, add-min and write-back fold stage
module tmps_fold import tmps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_issue    i_issue,
    input  logic      i_advance,
    output t_fold_res o_res
);

    // row buffer of running sums
    t_sum   mem [MAX_ROWS];

    logic   r_s1_valid;
    logic   n_s1_valid;
    logic   r_s1_bottom;
    logic   r_s1_apex;
    t_col   r_s1_col;
    t_value r_s1_value;
    t_sum   r_rd_a;
    t_sum   r_rd_b;

    t_col   addr_a;
    t_col   addr_b;
    logic   wr_en;
    t_sum   wr_data;
    t_sum   v_ext;
    t_sum   min_ab;

    // read addresses of the two neighbors below
    assign addr_a = i_issue.col;
    assign addr_b = i_issue.col + COL_W'(1);

    // fold: bottom row copies, higher rows add the smaller neighbor
    always_comb begin
        v_ext   = SUM_W'(r_s1_value);
        min_ab  = (r_rd_a < r_rd_b) ? r_rd_a : r_rd_b;
        wr_data = r_s1_bottom ? v_ext : (v_ext + min_ab);
    end

    assign wr_en = r_s1_valid & i_advance;

    // memory read with forwarding of the write in flight, and write-back
    always_ff @(posedge i_clk) begin
        if (i_issue.valid) begin
            r_rd_a <= (wr_en && (r_s1_col == addr_a)) ? wr_data : mem[addr_a];
            r_rd_b <= (wr_en && (r_s1_col == addr_b)) ? wr_data : mem[addr_b];
        end
        if (wr_en) begin
            mem[r_s1_col] <= wr_data;
        end
    end

    // fold stage occupancy
    always_comb begin
        if (i_issue.valid) begin
            n_s1_valid = 1'b1;
        end else if (i_advance) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // fold stage payload
    always_ff @(posedge i_clk) begin
        if (i_issue.valid) begin
            r_s1_bottom <= i_issue.bottom;
            r_s1_apex   <= i_issue.apex;
            r_s1_col    <= i_issue.col;
            r_s1_value  <= i_issue.value;
        end
    end

    assign o_res.valid = r_s1_valid;
    assign o_res.apex  = r_s1_apex;
    assign o_res.sum   = wr_data;

endmodule

/* tb/sv/tb_triangle_min_path_sum_core.sv */
// testbench for the triangle minimum path sum core: predicted sums checked beat by beat
`timescale 1ns / 1ps

module tb_triangle_min_path_sum_core;
    import tmps_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 760;
    localparam int PARTIAL_ITEMS = 100;
    localparam int HOLD_CYCLES   = 300;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;

    tmps_in_if  in_ch ();
    tmps_out_if out_ch ();

    triangle_min_path_sum_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // predictor state, mirrors the block after reset
    logic [CFG_W-1:0] rows_reg       = CFG_RESET;
    t_sum             row_sums [MAX_ROWS] = '{default: '0};
    int               rows_remaining = MAX_ROWS;
    int               next_col       = 0;
    t_out             sum_queue [$];

    // run bookkeeping
    int  errors            = 0;
    int  elements_accepted = 0;
    int  sums_checked      = 0;
    int  rows_writes       = 0;
    int  restarts          = 0;
    int  cycle_count       = 0;
    bit  steady            = 1'b0;
    int  sink_hold_cycles  = 0;
    bit  sink_holding      = 1'b0;

    // clock
    initial begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // cycle limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // row count in use for a register value
    function automatic int rows_in_use(input logic [CFG_W-1:0] setting);
        if (setting == '0) begin
            return 1;
        end
        if (int'(setting) > MAX_ROWS) begin
            return MAX_ROWS;
        end
        return int'(setting);
    endfunction

    // fold one element into the row sums, queue the sum after the apex
    function automatic void fold_element(input t_value v);
        int   rows;
        t_sum a;
        t_sum b;
        rows = rows_in_use(rows_reg);
        if (rows_remaining == 0 || rows_remaining > rows) begin
            rows_remaining = rows;
            next_col = 0;
        end
        if (next_col >= rows_remaining || next_col >= MAX_ROWS) begin
            next_col = 0;
        end
        if (rows_remaining == rows) begin
            row_sums[next_col] = t_sum'(v);
        end else begin
            a = row_sums[next_col];
            b = row_sums[next_col + 1];
            row_sums[next_col] = t_sum'(v) + ((a < b) ? a : b);
        end
        next_col++;
        if (next_col == rows_remaining) begin
            next_col = 0;
            rows_remaining--;
            if (rows_remaining == 0) begin
                sum_queue.push_back(t_out'(row_sums[0]));
                rows_remaining = rows;
            end
        end
    endfunction

    // track register writes and input beats, check result beats
    always @(posedge clk) begin : monitor
        t_out want;
        if (rst_n) begin
            if (cfg_we) begin
                rows_reg = cfg_data;
                rows_remaining = rows_in_use(cfg_data);
                next_col = 0;
            end
            if (in_ch.valid && in_ch.ready) begin
                elements_accepted++;
                fold_element(in_ch.value);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (sum_queue.size() == 0) begin
                    errors++;
                    $display("%0t unexpected min_sum beat: expected none, actual %0d",
                             $time, out_ch.min_sum);
                end else begin
                    want = sum_queue.pop_front();
                    sums_checked++;
                    if (out_ch.min_sum !== want) begin
                        errors++;
                        $display("%0t min_sum mismatch: expected %0d, actual %0d",
                                 $time, want, out_ch.min_sum);
                    end
                end
            end
        end
    end

    // result sink: random stall bursts, long hold-off on request
    initial begin : sink_drive
        int n;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (sink_hold_cycles != 0) begin
                n = sink_hold_cycles;
                sink_hold_cycles = 0;
                out_ch.ready <= 1'b0;
                sink_holding = 1'b1;
                repeat (n) @(negedge clk);
                sink_holding = 1'b0;
            end else if (!steady && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // element value biased toward the field extremes and small values near zero
    function automatic t_value pick_value();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return t_value'($urandom_range(0, 3)) - 16'sd2;
            default: return t_value'($urandom);
        endcase
    endfunction

    // offer one element beat, returns at the falling edge after acceptance
    task automatic send_value(input t_value v);
        if (!steady && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering, wait for every sum and let the pipeline empty
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (sum_queue.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // row count register write, only while idle
    task automatic write_rows(input logic [CFG_W-1:0] setting);
        cfg_we   <= 1'b1;
        cfg_data <= setting;
        @(negedge clk);
        cfg_we   <= 1'b0;
        rows_writes++;
    endtask

    // send a whole triangle for the given row count
    task automatic send_triangle(input int rows);
        for (int i = 0; i < rows * (rows + 1) / 2; i++) begin
            send_value(pick_value());
        end
    endtask

    // reset default and saturated counts: a full bottom row and part of the next, no sum due
    task automatic test_large_counts();
        for (int i = 0; i < PARTIAL_ITEMS; i++) begin
            send_value(16'sh7FFF);
        end
        wait_idle();
        write_rows(7'h7F);
        restarts++;
        for (int i = 0; i < PARTIAL_ITEMS; i++) begin
            send_value(16'sh8000);
        end
        restarts++;
    endtask

    // small triangles: zero and one row, ties, negative paths
    task automatic test_directed();
        wait_idle();
        write_rows(7'd0);
        send_value(16'sh7FFF);
        send_value(16'sh8000);
        send_value(16'sh0000);
        wait_idle();
        write_rows(7'd1);
        send_value(16'sd5);
        send_value(-16'sd1);
        wait_idle();
        write_rows(7'd2);
        send_value(16'sd1);
        send_value(16'sd2);
        send_value(16'sd3);
        send_value(16'sd4);
        send_value(16'sd4);
        send_value(-16'sd1);
        wait_idle();
        write_rows(7'd3);
        send_value(16'sd6);
        send_value(-16'sd5);
        send_value(16'sd7);
        send_value(16'sh7FFF);
        send_value(16'sh8000);
        send_value(16'sd2);
    endtask

    // register write in the middle of a triangle starts a fresh bottom row
    task automatic test_restart();
        wait_idle();
        write_rows(7'd64);
        repeat (10) send_value(pick_value());
        wait_idle();
        write_rows(7'd3);
        restarts++;
        send_triangle(3);
    endtask

    // long result hold-off with the sender still offering one-row triangles
    task automatic test_output_backpressure();
        wait_idle();
        write_rows(7'd1);
        sink_hold_cycles = HOLD_CYCLES;
        wait (sink_holding);
        repeat (40) send_value(pick_value());
    endtask

    // random triangles, mostly whole, some cut short by a register write
    task automatic test_random_triangles();
        int               start;
        int               rows;
        int               total;
        bit               need_write;
        logic [CFG_W-1:0] setting;
        start = elements_accepted;
        need_write = 1'b1;
        while (elements_accepted - start < RANDOM_ITEMS) begin
            if (need_write || $urandom_range(0, 2) != 0) begin
                wait_idle();
                case ($urandom_range(0, 9))
                    0: setting = 7'd0;
                    1: setting = 7'd1;
                    2, 3, 4, 5, 6: setting = CFG_W'($urandom_range(2, 6));
                    7, 8: setting = CFG_W'($urandom_range(7, 14));
                    default: setting = CFG_W'($urandom_range(15, 24));
                endcase
                write_rows(setting);
                need_write = 1'b0;
            end
            rows = rows_in_use(setting);
            total = rows * (rows + 1) / 2;
            if (total > 1 && $urandom_range(0, 9) == 0) begin
                // broken triangle, restarted by the next write
                repeat ($urandom_range(1, total - 1)) send_value(pick_value());
                need_write = 1'b1;
                restarts++;
            end else begin
                send_triangle(rows);
            end
        end
    endtask

    // back-to-back triangles with no idling on either side
    task automatic test_steady_stream();
        wait_idle();
        steady = 1'b1;
        write_rows(7'd4);
        repeat (12) send_triangle(4);
    endtask

    initial begin
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_large_counts();
        test_directed();
        test_restart();
        test_output_backpressure();
        test_random_triangles();
        test_steady_stream();
        wait_idle();

        $display("run covered %0d element beats and %0d checked sums over %0d row count writes",
                 elements_accepted, sums_checked, rows_writes);
        $display("included default and saturated counts, zero and one row, %0d restarts, hold-off",
                 restarts);
        if (errors == 0 && sum_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
